// ----- design/pthh_pkg.sv -----
// Shared constants and types for the three-hourly to hourly interpolator.
`default_nettype none
package pthh_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_BITS  = 8;
  localparam int GUARD_BITS = 8;
  localparam int SLOPE_FRAC = FRAC_BITS + GUARD_BITS;

  localparam int DAY_SLOTS = 8;
  localparam int KNOTS     = DAY_SLOTS + 1;
  localparam int DAY_HOURS = 24;
  localparam int SLOT_W    = $clog2(DAY_SLOTS);
  localparam int KNOT_W    = $clog2(KNOTS);
  localparam int HOUR_W    = 5;
  localparam int VALUE_W   = 24;

  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int SLOPE_W = SAMPLE_W + SLOPE_FRAC + 4;
  localparam int SUM_W   = SAMPLE_W + SLOPE_FRAC + 9;

  localparam int DIV_NUM_W = 2 * SAMPLE_W + SLOPE_FRAC + 1;
  localparam int DIV_DEN_W = SAMPLE_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // divide by 27 through a reciprocal multiply after dropping the guard bits
  localparam int HX_W        = DIV_NUM_W - GUARD_BITS;
  localparam int RECIP_IN_W  = SAMPLE_W + FRAC_BITS + 5;
  localparam int RECIP_SHIFT = RECIP_IN_W + 5;
  localparam logic [RECIP_IN_W:0] RECIP_MUL =
    (RECIP_IN_W + 1)'(((64'd1 << RECIP_SHIFT) + 64'd26) / 64'd27);
  localparam logic [HX_W-1:0] HOUR_LIMIT =
    HX_W'(64'd27 << (SAMPLE_W + FRAC_BITS));

  localparam logic [DIV_NUM_W-1:0] ROUND_HALF = DIV_NUM_W'((27 << GUARD_BITS) / 2);
  localparam logic [VALUE_W-1:0]   OUT_MAX    =
    VALUE_W'((64'd1 << (SAMPLE_W + FRAC_BITS)) - 64'd1);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- design/pthh_in_if.sv -----
// Input channel: one three-hourly sample per transfer.
`default_nettype none
interface pthh_in_if;
  import pthh_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;
  logic                sample_missing;
  modport source (output valid, sample_value, sample_missing, input ready);
  modport sink (input valid, sample_value, sample_missing, output ready);
endinterface
`default_nettype wire

// ----- design/pthh_out_if.sv -----
// Output channel: one hourly value per transfer.
`default_nettype none
interface pthh_out_if;
  import pthh_pkg::*;
  logic               valid;
  logic               ready;
  logic [HOUR_W-1:0]  hour_index;
  logic [VALUE_W-1:0] hourly_value;
  logic               last_of_day;
  modport source (output valid, hour_index, hourly_value, last_of_day, input ready);
  modport sink (input valid, hour_index, hourly_value, last_of_day, output ready);
endinterface
`default_nettype wire

// ----- design/pchip_three_hour_to_hourly.sv -----
// Three-hourly to hourly monotone cubic (PCHIP) interpolator, top level.
// A sample that completes no day is written straight to the sample memory. A first
// sample that closes a complete day starts an emission: nine knot slopes (an end or
// flat knot without the divider, any other knot through the 49-step divider), then
// 24 hours, each held until the output takes it, and a write-back of the endpoint;
// no sample is taken until then. Reset clears the slot count and day flags; the
// sample memory holds garbage until written.
`default_nettype none
module pchip_three_hour_to_hourly (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pthh_in_if.sink   in_i,
  pthh_out_if.source out_o
);
  import pthh_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SFETCH = 9'b000000010,
    ST_SCALC  = 9'b000000100,
    ST_SDIVST = 9'b000001000,
    ST_SDIV   = 9'b000010000,
    ST_HFETCH = 9'b000100000,
    ST_HCALC  = 9'b001000000,
    ST_HDIV   = 9'b010000000,
    ST_WRAP   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [SLOT_W-1:0]   slot_q;
  logic                all_present_q;
  logic                prev_ready_q;
  logic [SAMPLE_W-1:0] endpoint_q;
  logic [KNOT_W-1:0]   knot_q;
  logic [1:0]          fcnt_q;
  logic [HOUR_W-1:0]   hcnt_q;
  logic [KNOT_W-1:0]   k_q;
  logic [1:0]          p_q;
  logic                idx_end_q;
  logic                hdiv_q;
  logic                hdone_q;
  logic                outwait_q;

  logic [SAMPLE_W-1:0] w_q [3];
  logic [SAMPLE_W-1:0] yk_q, yk1_q;
  logic signed [SLOPE_W-1:0] sk_q, sk1_q;
  logic [2*SAMPLE_W-1:0] prod_q;
  logic [DIV_DEN_W-1:0]  ssum_q;
  logic                  sneg_q;
  logic [DIV_NUM_W-1:0]  vnum_q;
  logic [2*RECIP_IN_W:0] hprod_q;
  logic                  hover_q;

  logic                ovalid_q;
  logic [HOUR_W-1:0]   ohour_q;
  logic [VALUE_W-1:0]  ovalue_q;
  logic                olast_q;

  logic                in_xfer, emit;
  logic [KNOT_W-1:0]   sbase, idx;
  logic [SAMPLE_W-1:0] day_rdata, fetched;
  logic                day_we;
  logic [SLOT_W-1:0]   day_waddr;
  logic [SAMPLE_W-1:0] day_wdata;
  logic signed [SLOPE_W-1:0] slope_rdata, slope_wdata;
  logic                slope_we;
  logic signed [DIFF_W-1:0] d0, d1;
  logic                zero_slope, end_knot;
  logic [SAMPLE_W-1:0] amag, bmag;
  logic signed [SUM_W-1:0] yke, yk1e, ske, sk1e, vsum;
  logic [HX_W-1:0]     hx;
  logic                hover;
  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic signed [SLOPE_W-1:0] end_slope(
    input logic signed [DIFF_W-1:0] m0,
    input logic signed [DIFF_W-1:0] m1
  );
    logic signed [DIFF_W+2:0] m0e, m1e, n;
    logic [DIFF_W+2:0] an, a0;
    logic [SLOPE_W-1:0] mag;
    m0e = (DIFF_W+3)'(m0);
    m1e = (DIFF_W+3)'(m1);
    n   = m0e + m0e + m0e - m1e;
    an  = n[DIFF_W+2] ? -n : n;
    a0  = m0e[DIFF_W+2] ? -m0e : m0e;
    if (((n == '0) != (m0 == '0)) || (n[DIFF_W+2] != m0[DIFF_W-1])) begin
      return '0;
    end
    if ((((m0 == '0) != (m1 == '0)) || (m0[DIFF_W-1] != m1[DIFF_W-1])) &&
        (an > (a0 << 2) + (a0 << 1))) begin
      mag = SLOPE_W'((a0 + a0 + a0)) << SLOPE_FRAC;
    end else begin
      mag = SLOPE_W'(an) << (SLOPE_FRAC - 1);
    end
    return m0[DIFF_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

  assign in_xfer = in_i.valid && in_i.ready;
  assign emit    = (slot_q == '0) && prev_ready_q && !in_i.sample_missing;
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    if (knot_q == '0) begin
      sbase = '0;
    end else if (knot_q == KNOT_W'(DAY_SLOTS)) begin
      sbase = KNOT_W'(DAY_SLOTS - 2);
    end else begin
      sbase = knot_q - 1'b1;
    end
    idx = (state_q == ST_SFETCH) ? sbase + KNOT_W'(fcnt_q) : k_q + KNOT_W'(fcnt_q);
  end

  assign fetched = idx_end_q ? endpoint_q : day_rdata;

  assign day_we    = (in_xfer && !emit) || (state_q == ST_WRAP);
  assign day_waddr = (state_q == ST_WRAP) ? '0 : slot_q;
  assign day_wdata = (state_q == ST_WRAP) ? endpoint_q : in_i.sample_value;

  pthh_ram #(.WIDTH(SAMPLE_W), .DEPTH(DAY_SLOTS)) u_day_ram (
    .clk_i   (clk_i),
    .we_i    (day_we),
    .waddr_i (day_waddr),
    .wdata_i (day_wdata),
    .raddr_i (idx[SLOT_W-1:0]),
    .rdata_o (day_rdata)
  );

  pthh_ram #(.WIDTH(SLOPE_W), .DEPTH(KNOTS)) u_slope_ram (
    .clk_i   (clk_i),
    .we_i    (slope_we),
    .waddr_i (knot_q),
    .wdata_i (slope_wdata),
    .raddr_i (idx),
    .rdata_o (slope_rdata)
  );

  assign d0 = $signed({1'b0, w_q[1]}) - $signed({1'b0, w_q[0]});
  assign d1 = $signed({1'b0, w_q[2]}) - $signed({1'b0, w_q[1]});
  assign end_knot   = (knot_q == '0) || (knot_q == KNOT_W'(DAY_SLOTS));
  assign zero_slope = (d0 == '0) || (d1 == '0) || (d0[DIFF_W-1] != d1[DIFF_W-1]);
  assign amag = SAMPLE_W'(d0[DIFF_W-1] ? -d0 : d0);
  assign bmag = SAMPLE_W'(d1[DIFF_W-1] ? -d1 : d1);

  always_comb begin
    slope_we    = 1'b0;
    slope_wdata = '0;
    if (state_q == ST_SCALC) begin
      if (knot_q == '0) begin
        slope_we    = 1'b1;
        slope_wdata = end_slope(d0, d1);
      end else if (knot_q == KNOT_W'(DAY_SLOTS)) begin
        slope_we    = 1'b1;
        slope_wdata = end_slope(d1, d0);
      end else if (zero_slope) begin
        slope_we = 1'b1;
      end
    end else if (state_q == ST_SDIV && div_rsp.done) begin
      slope_we    = 1'b1;
      slope_wdata = sneg_q ? -$signed(div_rsp.quot[SLOPE_W-1:0])
                           : $signed(div_rsp.quot[SLOPE_W-1:0]);
    end
  end

  assign yke  = $signed(SUM_W'({yk_q, {SLOPE_FRAC{1'b0}}}));
  assign yk1e = $signed(SUM_W'({yk1_q, {SLOPE_FRAC{1'b0}}}));
  assign ske  = SUM_W'(sk_q);
  assign sk1e = SUM_W'(sk1_q);

  always_comb begin
    case (p_q)
      2'd1:    vsum = yke * $signed(SUM_W'(20)) + (ske <<< 2)
                      + yk1e * $signed(SUM_W'(7)) - (sk1e <<< 1);
      2'd2:    vsum = yke * $signed(SUM_W'(7)) + (ske <<< 1)
                      + yk1e * $signed(SUM_W'(20)) - (sk1e <<< 2);
      default: vsum = yke * $signed(SUM_W'(27));
    endcase
  end

  assign hx    = vnum_q[DIV_NUM_W-1:GUARD_BITS];
  assign hover = hx >= HOUR_LIMIT;

  always_comb begin
    div_req.start = (state_q == ST_SDIVST);
    div_req.num   = {prod_q, {(SLOPE_FRAC + 1){1'b0}}};
    div_req.den   = ssum_q;
  end

  pthh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer && emit) state_d = ST_SFETCH;
      ST_SFETCH: if (fcnt_q == 2'd3) state_d = ST_SCALC;
      ST_SCALC: begin
        if (!end_knot && !zero_slope) begin
          state_d = ST_SDIVST;
        end else if (knot_q == KNOT_W'(DAY_SLOTS)) begin
          state_d = ST_HFETCH;
        end else begin
          state_d = ST_SFETCH;
        end
      end
      ST_SDIVST: state_d = ST_SDIV;
      ST_SDIV:   if (div_rsp.done) state_d = ST_SFETCH;
      ST_HFETCH: if (fcnt_q == 2'd2) state_d = ST_HCALC;
      ST_HCALC:  if (hdiv_q) state_d = ST_HDIV;
      ST_HDIV: begin
        if (outwait_q && out_o.ready) begin
          state_d = (hcnt_q == HOUR_W'(DAY_HOURS - 1)) ? ST_WRAP : ST_HFETCH;
        end
      end
      ST_WRAP:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      slot_q        <= '0;
      all_present_q <= 1'b1;
      prev_ready_q  <= 1'b0;
      knot_q        <= '0;
      fcnt_q        <= '0;
      hcnt_q        <= '0;
      k_q           <= '0;
      p_q           <= '0;
      hdiv_q        <= 1'b0;
      hdone_q       <= 1'b0;
      outwait_q     <= 1'b0;
      ovalid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      hdone_q <= (state_q == ST_HCALC) && hdiv_q;
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (slot_q == '0) begin
              prev_ready_q  <= 1'b0;
              all_present_q <= !in_i.sample_missing;
            end else begin
              all_present_q <= all_present_q && !in_i.sample_missing;
              if (slot_q == SLOT_W'(DAY_SLOTS - 1)) begin
                prev_ready_q <= all_present_q && !in_i.sample_missing;
              end
            end
            slot_q <= slot_q + 1'b1;
            knot_q <= '0;
            fcnt_q <= '0;
            hcnt_q <= '0;
            k_q    <= '0;
            p_q    <= '0;
          end
        end
        ST_SFETCH: fcnt_q <= fcnt_q + 1'b1;
        ST_SCALC: begin
          fcnt_q <= '0;
          if (end_knot || zero_slope) begin
            knot_q <= knot_q + 1'b1;
          end
        end
        ST_SDIV: if (div_rsp.done) knot_q <= knot_q + 1'b1;
        ST_HFETCH: fcnt_q <= fcnt_q + 1'b1;
        ST_HCALC: begin
          fcnt_q <= '0;
          hdiv_q <= !hdiv_q;
        end
        ST_HDIV: begin
          if (hdone_q) begin
            ovalid_q  <= 1'b1;
            outwait_q <= 1'b1;
            hdiv_q    <= 1'b0;
          end
          if (outwait_q && out_o.ready) begin
            ovalid_q  <= 1'b0;
            outwait_q <= 1'b0;
            hcnt_q    <= hcnt_q + 1'b1;
            if (p_q == 2'd2) begin
              p_q <= '0;
              k_q <= k_q + 1'b1;
            end else begin
              p_q <= p_q + 1'b1;
            end
          end
        end
        ST_SDIVST, ST_WRAP: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    idx_end_q <= (idx == KNOT_W'(DAY_SLOTS));
    if (in_xfer) begin
      endpoint_q <= in_i.sample_value;
    end
    if (state_q == ST_SFETCH && fcnt_q != 2'd0) begin
      w_q[fcnt_q - 2'd1] <= fetched;
    end
    if (state_q == ST_SCALC) begin
      prod_q <= amag * bmag;
      ssum_q <= DIV_DEN_W'(amag) + DIV_DEN_W'(bmag);
      sneg_q <= d0[DIFF_W-1];
    end
    if (state_q == ST_HFETCH && fcnt_q == 2'd1) begin
      yk_q <= fetched;
      sk_q <= slope_rdata;
    end
    if (state_q == ST_HFETCH && fcnt_q == 2'd2) begin
      yk1_q <= fetched;
      sk1_q <= slope_rdata;
    end
    if (state_q == ST_HCALC && !hdiv_q) begin
      vnum_q <= (vsum > 0) ? DIV_NUM_W'(vsum) + ROUND_HALF : '0;
    end
    if (state_q == ST_HCALC && hdiv_q) begin
      hprod_q <= (2*RECIP_IN_W+1)'(hx[RECIP_IN_W-1:0]) * (2*RECIP_IN_W+1)'(RECIP_MUL);
      hover_q <= hover;
    end
    if (state_q == ST_HDIV && hdone_q) begin
      ohour_q  <= hcnt_q;
      ovalue_q <= hover_q ? OUT_MAX : hprod_q[RECIP_SHIFT +: VALUE_W];
      olast_q  <= (hcnt_q == HOUR_W'(DAY_HOURS - 1));
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.hour_index   = ohour_q;
  assign out_o.hourly_value = ovalue_q;
  assign out_o.last_of_day  = olast_q;
endmodule
`default_nettype wire

// ----- design/pthh_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pthh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- design/pthh_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module pthh_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pthh_pkg::div_req_t req_i,
  output      pthh_pkg::div_rsp_t rsp_o
);
  import pthh_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic                 done_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= DIV_CNT_W'(DIV_NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= req_i.den;
      quo_q <= req_i.num;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
endmodule
`default_nettype wire

// ----- tb/tb_pchip_three_hour_to_hourly.sv -----
// Testbench for the three-hourly to hourly PCHIP interpolator: predicts and checks hourly values.
`default_nettype none
module tb_pchip_three_hour_to_hourly;
  import pthh_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                missing;
  } sample_t;

  typedef struct packed {
    logic [HOUR_W-1:0]  hour;
    logic [VALUE_W-1:0] value;
    logic               last;
  } hour_rec_t;

  localparam longint LIMIT_CYCLES = 2000000;
  localparam int     HOLD_CYCLES  = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pthh_in_if  in_if ();
  pthh_out_if out_if ();

  pchip_three_hour_to_hourly dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sample_t   pending_samples[$];
  hour_rec_t hourly_expect[$];
  int        total_samples;
  int        samples_taken = 0;
  int        hours_seen = 0;
  int        errors = 0;
  longint    cycle_count = 0;
  logic      in_fire = 1'b0;
  logic      long_hold = 1'b0;

  longint day_vals[DAY_SLOTS];
  int     day_slot = 0;
  logic   day_complete = 1'b1;
  logic   day_waiting = 1'b0;

  function automatic int sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint edge_slope(longint m0, longint m1);
    longint n;
    n = 3 * m0 - m1;
    if (sgn(n) != sgn(m0)) return 0;
    if (sgn(m0) != sgn(m1) && mag(n) > 6 * mag(m0))
      return sgn(m0) * ((mag(m0) * 3) << SLOPE_FRAC);
    return sgn(n) * (mag(n) << (SLOPE_FRAC - 1));
  endfunction

  function automatic longint knot_slope(longint d0, longint d1);
    longint a, b, s, q, r, whole, part;
    if (sgn(d0) * sgn(d1) <= 0) return 0;
    a = mag(d0);
    b = mag(d1);
    s = a + b;
    q = (a * a) / s;
    r = (a * a) % s;
    whole = (a - q) << (SLOPE_FRAC + 1);
    part = ((r << (SLOPE_FRAC + 1)) + s - 1) / s;
    return sgn(d0) * (whole - part);
  endfunction

  function automatic void predict_day(longint endpoint);
    longint    y[KNOTS];
    longint    d[DAY_SLOTS];
    longint    sl[KNOTS];
    longint    c[3][4];
    longint    v, res, dv;
    int        k, p;
    hour_rec_t rec;
    c = '{'{27, 0, 0, 0}, '{20, 4, 7, -2}, '{7, 2, 20, -4}};
    dv = 27 << GUARD_BITS;
    for (int i = 0; i < DAY_SLOTS; i++) y[i] = day_vals[i];
    y[DAY_SLOTS] = endpoint;
    for (int i = 0; i < DAY_SLOTS; i++) d[i] = y[i+1] - y[i];
    sl[0] = edge_slope(d[0], d[1]);
    sl[DAY_SLOTS] = edge_slope(d[DAY_SLOTS-1], d[DAY_SLOTS-2]);
    for (int i = 1; i < DAY_SLOTS; i++) sl[i] = knot_slope(d[i-1], d[i]);
    for (int h = 0; h < DAY_HOURS; h++) begin
      k = h / 3;
      p = h % 3;
      v = c[p][0] * (y[k] << SLOPE_FRAC) + c[p][1] * sl[k]
        + c[p][2] * (y[k+1] << SLOPE_FRAC) + c[p][3] * sl[k+1];
      res = 0;
      if (v > 0) res = (v + dv / 2) / dv;
      if (res > (64'd1 << (SAMPLE_W + FRAC_BITS)) - 1)
        res = (64'd1 << (SAMPLE_W + FRAC_BITS)) - 1;
      rec.hour = HOUR_W'(h);
      rec.value = VALUE_W'(res);
      rec.last = (h == DAY_HOURS - 1);
      hourly_expect.insert(hourly_expect.size(), rec);
    end
  endfunction

  function automatic void take_sample(sample_t s);
    if (day_slot == 0) begin
      if (day_waiting && !s.missing) predict_day(longint'(s.value));
      day_waiting = 1'b0;
      day_complete = !s.missing;
    end else begin
      day_complete = day_complete && !s.missing;
    end
    day_vals[day_slot] = longint'(s.value);
    if (day_slot == DAY_SLOTS - 1) day_waiting = day_complete;
    day_slot = (day_slot + 1) % DAY_SLOTS;
  endfunction

  function automatic void queue_sample(int v, bit m);
    sample_t s;
    s.value = SAMPLE_W'(v);
    s.missing = m;
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  function automatic void queue_random_day();
    int style, base, step;
    bit noisy;
    style = $urandom_range(0, 9);
    noisy = (style == 9);
    base = $urandom_range(0, 65535);
    step = $urandom_range(0, 8000);
    for (int i = 0; i < DAY_SLOTS; i++) begin
      int v;
      case (style)
        0, 1, 2: v = $urandom_range(0, 65535);
        3, 4: begin
          v = base + $urandom_range(0, 100) - 50;
          v = v < 0 ? 0 : (v > 65535 ? 65535 : v);
        end
        5: v = (base + i * step) % 65536;
        6: v = (i % 2) ? 65535 - $urandom_range(0, 3) : $urandom_range(0, 3);
        7: v = $urandom_range(0, 15);
        default: v = $urandom_range(0, 65535);
      endcase
      queue_sample(v, noisy ? $urandom_range(0, 1) : ($urandom_range(0, 39) == 0));
    end
  endfunction

  // sender idle and receiver stall percentages by phase
  function automatic int send_idle_pct();
    if (samples_taken < 80) return 0;
    if (samples_taken < 160) return 51;
    if (samples_taken < 240) return 0;
    return 31;
  endfunction

  function automatic int recv_stall_pct();
    if (samples_taken < 160) return 0;
    if (samples_taken < 240) return 51;
    return 31;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[pchip_three_hour_to_hourly] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    in_fire <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      sample_t s;
      s.value = in_if.sample_value;
      s.missing = in_if.sample_missing;
      take_sample(s);
      samples_taken++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      hours_seen++;
      if (hourly_expect.size() == 0) begin
        $display("%0t: unexpected hour %0d value %0d last %0b", $realtime,
                 out_if.hour_index, out_if.hourly_value, out_if.last_of_day);
        errors++;
      end else begin
        hour_rec_t e;
        e = hourly_expect.pop_front();
        if (e.hour != out_if.hour_index) begin
          $display("%0t: hour_index expected %0d actual %0d", $realtime, e.hour,
                   out_if.hour_index);
          errors++;
        end
        if (e.value != out_if.hourly_value) begin
          $display("%0t: hour %0d hourly_value expected %0d actual %0d", $realtime,
                   e.hour, e.value, out_if.hourly_value);
          errors++;
        end
        if (e.last != out_if.last_of_day) begin
          $display("%0t: hour %0d last_of_day expected %0b actual %0b", $realtime,
                   e.hour, e.last, out_if.last_of_day);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_fire) begin
        if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          sample_t s;
          s = pending_samples.pop_front();
          in_if.valid <= 1'b1;
          in_if.sample_value <= s.value;
          in_if.sample_missing <= s.missing;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= !long_hold && ($urandom_range(0, 99) >= recv_stall_pct());
    end
  end

  // hold the receiver off for a long stretch while the sender keeps offering samples
  initial begin
    wait (hours_seen >= 30);
    @(negedge clk_i);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.sample_value = '0;
    in_if.sample_missing = 1'b0;
    out_if.ready = 1'b0;

    for (int i = 0; i < DAY_SLOTS; i++) queue_sample((i % 2) ? 65535 : 0, 1'b0);
    for (int i = 0; i < DAY_SLOTS; i++) queue_sample(i * 1000, 1'b0);
    queue_sample(65535, 1'b1);
    for (int i = 1; i < DAY_SLOTS; i++) queue_sample(500, 1'b0);
    queue_sample(65535, 1'b0);
    for (int i = 1; i < DAY_SLOTS; i++) queue_sample(65535 - i * 9000, i == 4);
    while (pending_samples.size() < 328) queue_random_day();
    queue_sample($urandom_range(0, 65535), 1'b0);
    total_samples = pending_samples.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (samples_taken == total_samples);
    wait (hourly_expect.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && hourly_expect.size() == 0) begin
      $display("[pchip_three_hour_to_hourly] OK");
    end else begin
      $display("[pchip_three_hour_to_hourly] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
